// ----- rtl/slab_pkg.sv -----
// ----------------------------------------------------------------------------
// slab_pkg: shared types, codes and constants of the slab allocator
// Request and response structs, function and status codes, default
// configuration and the size-class table function.
// ----------------------------------------------------------------------------
package slab_pkg;

  // Fixed field widths
  localparam int FUNC_W  = 2;
  localparam int SIZE_W  = 20;
  localparam int CLASS_W = 3;
  localparam int ADDR_W  = 26;
  localparam int STAT_W  = 2;

  // Default configuration
  localparam int NUM_CLASSES_DEF     = 8;
  localparam int NUM_SLABS_DEF       = 64;
  localparam int SLAB_BYTES_LOG2_DEF = 20;
  localparam int FREE_DEPTH_DEF      = 64;
  localparam int BASE_ITEM_BYTES_DEF = 1200;
  localparam int GROWTH_DEF          = 2;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_MEM   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [SIZE_W-1:0]  request_size;
    logic [CLASS_W-1:0] class_id;
    logic [ADDR_W-1:0]  address;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CLASS_W-1:0] found_class;
    logic [ADDR_W-1:0]  item_address;
  } rsp_t;

  // Item size of class k: base grown k times, capped at the slab size
  // after every step. Evaluated at elaboration only.
  function automatic longint class_bytes(int k, int base, int growth, int slab_log2);
    longint sz;
    longint cap;
    sz  = longint'(base);
    cap = longint'(1) << slab_log2;
    for (int i = 0; i <= k; i++) begin
      if (sz > cap) begin
        sz = cap;
      end
      if (i < k) begin
        sz = sz * longint'(growth);
      end
    end
    return sz;
  endfunction

endpackage

// ----- rtl/slab_size_map.sv -----
// ----------------------------------------------------------------------------
// slab_size_map: request size to size class
// Compares the size against every class size in parallel and picks the
// lowest class that fits. Zero or oversize requests give no hit.
// ----------------------------------------------------------------------------
module slab_size_map #(
  parameter int NUM_CLASSES     = slab_pkg::NUM_CLASSES_DEF,
  parameter int SLAB_BYTES_LOG2 = slab_pkg::SLAB_BYTES_LOG2_DEF,
  parameter int BASE_ITEM_BYTES = slab_pkg::BASE_ITEM_BYTES_DEF,
  parameter int GROWTH          = slab_pkg::GROWTH_DEF
) (
  input  logic [slab_pkg::SIZE_W-1:0]  size,
  output logic                         hit,
  output logic [slab_pkg::CLASS_W-1:0] found
);
  import slab_pkg::*;

  localparam int CMP_W = (SIZE_W > SLAB_BYTES_LOG2 + 1) ? SIZE_W : SLAB_BYTES_LOG2 + 1;

  logic [NUM_CLASSES-1:0] fits;

  // One compare per class
  for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_cmp
    localparam longint CB = class_bytes(k, BASE_ITEM_BYTES, GROWTH, SLAB_BYTES_LOG2);
    assign fits[k] = (CMP_W'(size) <= CMP_W'(CB));
  end

  // Lowest fitting class wins
  always_comb begin
    hit   = 1'b0;
    found = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (fits[k]) begin
        hit   = 1'b1;
        found = CLASS_W'(k);
      end
    end
    if (size == '0) begin
      hit   = 1'b0;
      found = '0;
    end
  end

endmodule

// ----- rtl/slab_free_ram.sv -----
// ----------------------------------------------------------------------------
// slab_free_ram: free-list storage
// Single write port, single registered read port with read enable.
// ----------------------------------------------------------------------------
module slab_free_ram #(
  parameter int AW = 9,
  parameter int DW = slab_pkg::ADDR_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/slab_allocator.sv -----
// ----------------------------------------------------------------------------
// slab_allocator: slab allocator with size classes for one partition
// A request is taken into an input register, decided against the per-class
// state and registered as a response; the next request can be taken while
// one is being decided, so the block sustains one request per clock while
// the output is not stalled. A request moves from the input register to
// the response register once the output is free. A popped address comes
// from the registered read port of the free-list RAM, which is read in the
// decision cycle and feeds the response address directly. Free-list
// entries come up undefined and need no clearing; the block is ready
// straight after reset. Slabs are handed out from the highest-numbered one
// down and are never returned.
// ----------------------------------------------------------------------------
module slab_allocator #(
  parameter int NUM_CLASSES     = slab_pkg::NUM_CLASSES_DEF,
  parameter int NUM_SLABS       = slab_pkg::NUM_SLABS_DEF,
  parameter int SLAB_BYTES_LOG2 = slab_pkg::SLAB_BYTES_LOG2_DEF,
  parameter int FREE_DEPTH      = slab_pkg::FREE_DEPTH_DEF,
  parameter int BASE_ITEM_BYTES = slab_pkg::BASE_ITEM_BYTES_DEF,
  parameter int GROWTH          = slab_pkg::GROWTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  slab_pkg::req_t       in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output slab_pkg::rsp_t       out_data
);
  import slab_pkg::*;

  localparam int CI_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int FD_W = $clog2(FREE_DEPTH);
  localparam int FC_W = $clog2(FREE_DEPTH + 1);
  localparam int FS_W = $clog2(NUM_SLABS + 1);
  localparam int IL_W = SLAB_BYTES_LOG2;
  localparam int RA_W = CI_W + FD_W;

  // Per-class constants
  logic [ADDR_W-1:0] isz_tbl [NUM_CLASSES];
  logic [IL_W-1:0]   ips_tbl [NUM_CLASSES];

  for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_cls
    localparam longint CB  = class_bytes(k, BASE_ITEM_BYTES, GROWTH, SLAB_BYTES_LOG2);
    localparam longint IPS = (longint'(1) << SLAB_BYTES_LOG2) / CB;
    assign isz_tbl[k] = ADDR_W'(CB);
    assign ips_tbl[k] = IL_W'(IPS - 1);
  end

  // Pipeline registers
  logic              s1_valid_r;
  req_t              s1_r;
  logic              out_valid_r;
  rsp_t              out_r;
  logic              out_mem_r;

  // Per-class state
  logic [FD_W-1:0]   head_r  [NUM_CLASSES];
  logic [FD_W-1:0]   tail_r  [NUM_CLASSES];
  logic [FC_W-1:0]   count_r [NUM_CLASSES];
  logic              cur_r   [NUM_CLASSES];
  logic [ADDR_W-1:0] bump_r  [NUM_CLASSES];
  logic [IL_W-1:0]   left_r  [NUM_CLASSES];
  logic [FS_W-1:0]   free_slabs_r;

  // Decision signals
  logic              s2_ready;
  logic              s1_fire;
  logic              cls_ok;
  logic [CI_W-1:0]   ci;
  logic              map_hit;
  logic [CLASS_W-1:0] map_class;
  logic              pop_en;
  logic              bump_en;
  logic              slab_en;
  logic              push_en;
  rsp_t              rsp;
  logic [FS_W-1:0]   slabs_m1;
  logic [ADDR_W-1:0] slab_base;
  logic [ADDR_W-1:0] ram_q;

  // Handshake
  assign s2_ready  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && s2_ready;
  assign in_stall  = s1_valid_r && !s2_ready;
  assign out_valid = out_valid_r;

  // Class index and range check
  assign cls_ok    = (int'(s1_r.class_id) < NUM_CLASSES);
  assign ci        = CI_W'(s1_r.class_id);
  assign slabs_m1  = free_slabs_r - FS_W'(1);
  assign slab_base = ADDR_W'({slabs_m1, {SLAB_BYTES_LOG2{1'b0}}});

  slab_size_map #(
    .NUM_CLASSES     (NUM_CLASSES),
    .SLAB_BYTES_LOG2 (SLAB_BYTES_LOG2),
    .BASE_ITEM_BYTES (BASE_ITEM_BYTES),
    .GROWTH          (GROWTH)
  ) u_size_map (
    .size  (s1_r.request_size),
    .hit   (map_hit),
    .found (map_class)
  );

  slab_free_ram #(
    .AW (RA_W),
    .DW (ADDR_W)
  ) u_free_ram (
    .clk   (clk),
    .we    (s1_fire && push_en),
    .waddr ({ci, tail_r[ci]}),
    .wdata (s1_r.address),
    .re    (s1_fire && pop_en),
    .raddr ({ci, head_r[ci]}),
    .rdata (ram_q)
  );

  // Request decode and response
  always_comb begin
    pop_en  = 1'b0;
    bump_en = 1'b0;
    slab_en = 1'b0;
    push_en = 1'b0;
    rsp     = '0;
    case (s1_r.func)
      FUNC_LOOKUP: begin
        if (map_hit) begin
          rsp.found_class = map_class;
        end else begin
          rsp.status = ST_BAD_SIZE;
        end
      end
      FUNC_ALLOC: begin
        if (!cls_ok) begin
          rsp.status = ST_BAD_SIZE;
        end else if (count_r[ci] != '0) begin
          pop_en = 1'b1;
        end else if (cur_r[ci] && left_r[ci] != '0) begin
          bump_en           = 1'b1;
          rsp.item_address  = bump_r[ci];
        end else if (free_slabs_r != '0) begin
          slab_en           = 1'b1;
          rsp.item_address  = slab_base;
        end else begin
          rsp.status = ST_NO_MEM;
        end
      end
      FUNC_FREE: begin
        if (!cls_ok) begin
          rsp.status = ST_BAD_SIZE;
        end else if (count_r[ci] == FC_W'(FREE_DEPTH)) begin
          rsp.status = ST_FULL;
        end else begin
          push_en = 1'b1;
        end
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || s1_fire) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r     <= rsp;
      out_mem_r <= pop_en;
    end
  end

  // Popped address comes straight from the RAM read register
  always_comb begin
    out_data = out_r;
    if (out_mem_r) begin
      out_data.item_address = ram_q;
    end
  end

  // Per-class state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        head_r[k]  <= '0;
        tail_r[k]  <= '0;
        count_r[k] <= '0;
        cur_r[k]   <= 1'b0;
        bump_r[k]  <= '0;
        left_r[k]  <= '0;
      end
      free_slabs_r <= FS_W'(NUM_SLABS);
    end else if (s1_fire) begin
      if (pop_en) begin
        head_r[ci]  <= (head_r[ci] == FD_W'(FREE_DEPTH - 1)) ? '0 : head_r[ci] + FD_W'(1);
        count_r[ci] <= count_r[ci] - FC_W'(1);
      end
      if (push_en) begin
        tail_r[ci]  <= (tail_r[ci] == FD_W'(FREE_DEPTH - 1)) ? '0 : tail_r[ci] + FD_W'(1);
        count_r[ci] <= count_r[ci] + FC_W'(1);
      end
      if (bump_en) begin
        bump_r[ci] <= bump_r[ci] + isz_tbl[ci];
        left_r[ci] <= left_r[ci] - IL_W'(1);
      end
      if (slab_en) begin
        free_slabs_r <= slabs_m1;
        cur_r[ci]    <= 1'b1;
        bump_r[ci]   <= slab_base + isz_tbl[ci];
        left_r[ci]   <= ips_tbl[ci];
      end
    end
  end

  // Checks
  a_slabs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_slabs_r <= FS_W'(NUM_SLABS))
    else $error("free slab count above slab total");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && cls_ok |-> count_r[ci] <= FC_W'(FREE_DEPTH))
    else $error("free list count above depth");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && pop_en |=> out_valid_r && out_mem_r && out_r.status == ST_OK)
    else $error("free-list pop not carried to the response");

  a_slab_take: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && slab_en |=> free_slabs_r == $past(free_slabs_r) - FS_W'(1))
    else $error("slab take did not consume one slab");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0({pop_en, bump_en, slab_en, push_en}))
    else $error("more than one state action for a request");

endmodule
